/* hdl/frm_pkg.sv */
package frm_pkg;

  localparam int FRAME_TIME_W = 24;
  localparam int RATE_W       = 28;
  localparam int INTERVAL_W   = 26;
  localparam int SUM_W        = 28;
  localparam int COUNT_W      = 26;
  localparam int SCALE_W      = 20;
  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 32;
  localparam int OUT_TUSER_W  = 2;
  localparam int CFG_IDX_W    = 2;

  localparam logic [SCALE_W-1:0]    US_PER_SEC       = 20'd1000000;
  localparam logic [INTERVAL_W-1:0] INSTANT_LIMIT_US = 26'd10000;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET   = 26'd500000;
  localparam logic [RATE_W-1:0]     RATE_MAX         = '1;
  localparam logic [COUNT_W-1:0]    COUNT_MAX        = '1;

  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd1;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic clear_all;
    logic load_inst;
    logic accumulate;
    logic load_avg;
    logic div_start;
    logic commit;
    logic out_load;
  } frm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic t_zero;
    logic enable;
    logic instant;
    logic window_done;
    logic div_done;
    logic out_free;
  } frm_sts_t;

endpackage

/* hdl/frm_div.sv */
module frm_div #(
  parameter int NUM_W = 54
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [NUM_W-1:0]          num,
  input  logic [frm_pkg::SUM_W-1:0] den,
  output logic                      done,
  output logic [frm_pkg::RATE_W-1:0] quot
);
  import frm_pkg::*;

  localparam int Q_W   = RATE_W;
  localparam int HI_W  = NUM_W - Q_W;
  localparam int CNT_W = $clog2(Q_W + 1);
  localparam int CMP_W = (HI_W > SUM_W) ? HI_W : SUM_W;

  logic [HI_W-1:0]  num_hi;
  logic             ovf;
  logic [SUM_W-1:0] den_r;
  logic [SUM_W-1:0] rem_r;
  logic [Q_W-1:0]   nlo_r;
  logic [Q_W-1:0]   q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             sat_r;
  logic             done_r;
  logic [SUM_W+1:0] diff;

  assign num_hi = num[NUM_W-1:Q_W];
  assign ovf    = (CMP_W'(num_hi) >= CMP_W'(den));
  assign diff   = {1'b0, rem_r, nlo_r[Q_W-1]} - {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(Q_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      sat_r <= ovf;
      rem_r <= ovf ? '0 : SUM_W'(num_hi);
      nlo_r <= num[Q_W-1:0];
      q_r   <= '0;
    end else if (run_r) begin
      if (!diff[SUM_W+1]) begin
        rem_r <= diff[SUM_W-1:0];
      end else begin
        rem_r <= {rem_r[SUM_W-2:0], nlo_r[Q_W-1]};
      end
      nlo_r <= {nlo_r[Q_W-2:0], 1'b0};
      q_r   <= {q_r[Q_W-2:0], ~diff[SUM_W+1]};
    end
  end

  assign done = done_r;
  assign quot = sat_r ? RATE_MAX : q_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> !start) else $error("divider restarted while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !run_r) else $error("divider done while still running");
  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> run_r && cnt_r == CNT_W'(Q_W)) else $error("divider failed to start");

endmodule

/* hdl/frm_dp.sv */
module frm_dp #(
  parameter int FRAC_BITS  = 8,
  parameter int TIME_WIDTH = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  frm_pkg::frm_cmd_t                cmd,
  output frm_pkg::frm_sts_t                sts,
  input  logic [frm_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             cfg_valid,
  input  logic [frm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [frm_pkg::INTERVAL_W-1:0]   cfg_data,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [frm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [frm_pkg::OUT_TUSER_W-1:0]  out_tuser
);
  import frm_pkg::*;

  localparam int PROD_W = COUNT_W + SCALE_W;
  localparam int NUM_W  = PROD_W + FRAC_BITS;
  localparam logic [FRAME_TIME_W-1:0] T_MASK = (TIME_WIDTH >= FRAME_TIME_W) ? '1 :
    FRAME_TIME_W'((64'd1 << TIME_WIDTH) - 64'd1);

  logic [INTERVAL_W-1:0]   interval_r;
  logic                    enable_r;
  logic [FRAME_TIME_W-1:0] t_r;
  logic [SUM_W-1:0]        time_sum_r;
  logic [COUNT_W-1:0]      frame_count_r;
  logic [RATE_W-1:0]       shown_rate_r;
  logic                    shown_valid_r;
  logic                    fresh_r;
  logic [COUNT_W-1:0]      mul_a_r;
  logic [SUM_W-1:0]        den_r;
  logic [PROD_W-1:0]       product_r;
  logic [RATE_W-1:0]       out_rate_r;
  logic                    out_valid_flag_r;
  logic                    out_fresh_r;
  logic                    out_tvalid_r;
  logic [SUM_W:0]          sum_ext;
  logic [SUM_W-1:0]        time_sum_nxt;
  logic [NUM_W-1:0]        num;
  logic                    div_done;
  logic [RATE_W-1:0]       quot;
  logic                    inst_mode;

  assign sum_ext      = {1'b0, time_sum_r} + (SUM_W+1)'(t_r);
  assign time_sum_nxt = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  assign num          = NUM_W'(product_r) << FRAC_BITS;
  assign inst_mode    = (interval_r < INSTANT_LIMIT_US);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r    <= INTERVAL_RESET;
      enable_r      <= 1'b1;
      time_sum_r    <= '0;
      frame_count_r <= '0;
      shown_rate_r  <= '0;
      shown_valid_r <= 1'b0;
      fresh_r       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == REG_INTERVAL) begin
        interval_r    <= cfg_data;
        time_sum_r    <= '0;
        frame_count_r <= '0;
      end else if (cfg_valid && cfg_index == REG_ENABLE) begin
        enable_r <= cfg_data[0];
      end
      if (cmd.capture) begin
        fresh_r <= 1'b0;
      end
      if (cmd.clear_all) begin
        time_sum_r    <= '0;
        frame_count_r <= '0;
        shown_rate_r  <= '0;
        shown_valid_r <= 1'b0;
      end
      if (cmd.accumulate) begin
        time_sum_r <= time_sum_nxt;
        if (frame_count_r != COUNT_MAX) begin
          frame_count_r <= frame_count_r + 1'b1;
        end
      end
      if (cmd.commit) begin
        shown_rate_r  <= quot;
        shown_valid_r <= 1'b1;
        if (!inst_mode) begin
          fresh_r       <= 1'b1;
          time_sum_r    <= '0;
          frame_count_r <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      t_r <= in_tdata[FRAME_TIME_W-1:0] & T_MASK;
    end
    if (cmd.load_inst) begin
      mul_a_r <= COUNT_W'(1);
      den_r   <= SUM_W'(t_r);
    end else if (cmd.load_avg) begin
      mul_a_r <= frame_count_r;
      den_r   <= time_sum_r;
    end
    product_r <= mul_a_r * US_PER_SEC;
  end

  frm_div #(.NUM_W(NUM_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num),
    .den   (den_r),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_rate_r       <= shown_rate_r;
      out_valid_flag_r <= shown_valid_r;
      out_fresh_r      <= fresh_r;
    end
  end

  assign sts.t_zero      = (t_r == '0);
  assign sts.enable      = enable_r;
  assign sts.instant     = inst_mode;
  assign sts.window_done = (time_sum_r >= SUM_W'(interval_r));
  assign sts.div_done    = div_done;
  assign sts.out_free    = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'(out_rate_r);
  assign out_tuser  = {out_fresh_r, out_valid_flag_r};

  a_avg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && !inst_mode && !cfg_valid |=> time_sum_r == '0 && frame_count_r == '0)
    else $error("window sums not restarted");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_all |=> shown_rate_r == '0 && !shown_valid_r)
    else $error("clear left a shown rate");
  a_fresh_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r |-> shown_valid_r) else $error("fresh without a valid rate");

endmodule

/* hdl/frm_ctrl.sv */
module frm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  frm_pkg::frm_sts_t sts,
  output frm_pkg::frm_cmd_t cmd
);
  import frm_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_DIVGO  = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (sts.t_zero) begin
          state_nxt = S_OUT;
        end else if (!sts.enable) begin
          cmd.clear_all = 1'b1;
          state_nxt     = S_OUT;
        end else if (sts.instant) begin
          cmd.load_inst = 1'b1;
          state_nxt     = S_MUL;
        end else begin
          cmd.accumulate = 1'b1;
          state_nxt      = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.window_done) begin
          cmd.load_avg = 1'b1;
          state_nxt    = S_MUL;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_MUL: state_nxt = S_DIVGO;
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.commit = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free) else $error("result overwrote a pending transaction");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_DECIDE) else $error("accepted item not processed");
  a_commit_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> $past(state_r) == S_DIV || $past(state_r) == S_DIVGO)
    else $error("commit without a division");

endmodule

/* hdl/frame_rate_meter.sv */
// Flow: a zero-duration or disabled item goes from acceptance straight to the output register, a
// non-closing averaging item through the window check first; an item that needs a rate (also after
// a closing window check) passes the 28-step restoring divider behind a registered multiply.
// One item in flight; the next is accepted the cycle after the result is loaded into the output
// register; the load waits while the output is stalled.
// Reset (rst_n, synchronous): interval 500000 us, measurement enabled, all sums and rate cleared.
module frame_rate_meter #(
  parameter int FRAC_BITS  = 8,
  parameter int TIME_WIDTH = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [frm_pkg::IN_TDATA_W-1:0]   in_tdata,   // [23:0] frame_time_us
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [frm_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [27:0] rate_q8, [31:28] zero
  output logic [frm_pkg::OUT_TUSER_W-1:0]  out_tuser,  // [0] rate_valid, [1] rate_fresh
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [frm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [frm_pkg::INTERVAL_W-1:0]   cfg_data
);
  import frm_pkg::*;

  frm_cmd_t cmd;
  frm_sts_t sts;

  assign cfg_ready = 1'b1;

  frm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  frm_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
